// ----- rtl/wsfu_pkg.sv -----
// Shared types and constants for the websocket frame unmask block.
`default_nettype none
package wsfu_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXT_HI = 3'd2,
		PH_EXT_LO = 3'd3,
		PH_MASK   = 3'd4,
		PH_DATA   = 3'd5
	} phase_t;

	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_BADHDR  = 3'd2;
	localparam logic [2:0] ST_LEN64   = 3'd3;
	localparam logic [2:0] ST_TOOLONG = 3'd4;

	localparam logic [6:0]  LEN_EXT16   = 7'd126;
	localparam logic [6:0]  LEN_EXT64   = 7'd127;
	localparam logic [15:0] MASK_BYTES  = 16'd4;
	localparam logic [15:0] MAX_LEN_RST = 16'd1024;

	// header_flags bits
	localparam int FLAG_FIN  = 0;
	localparam int FLAG_MASK = 1;

endpackage
`default_nettype wire

// ----- rtl/websocket_frame_unmask.sv -----
// Top level: websocket client frame parser and payload unmasker.
`default_nettype none
// Takes one raw frame byte per beat (start_of_frame marks the first header
// byte) and returns one result beat per payload byte, XORed with the frame's
// mask key, with last set on the final byte. Header, extended length and mask
// bytes produce no beat, except that an empty payload gives one completion
// beat and a rejected header gives one status beat; bytes after a rejection
// or a finished frame are dropped until the next start mark. Each input beat
// is parsed in the cycle it is accepted and its result is captured in the output
// register at the edge that accepts it; one beat per cycle is sustained whenever the
// consumer keeps out_ready high, set by the single output register, which
// also accepts a new beat in the cycle its held result is taken.
// max_payload_length must be written only while no frame is in flight.
module websocket_frame_unmask
	import wsfu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        start_of_frame,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       payload_byte,
	output logic             last,
	output logic [2:0]       status,
	output logic [15:0]      frame_length
);

	logic [15:0] max_len_q;
	phase_t      phase_q, phase_d;
	logic [1:0]  flags_q, flags_d;
	logic [15:0] plen_q, plen_d;
	logic [15:0] count_q, count_d;
	logic [31:0] key_q, key_d;

	logic        res_vld;
	logic [7:0]  res_byte;
	logic        res_last;
	logic [2:0]  res_status;
	logic [15:0] res_len;

	logic        accept;
	logic [6:0]  len7;
	logic [1:0]  hdr_flags;
	logic [15:0] ext_len;
	logic [15:0] count_inc;
	logic [7:0]  key_byte;
	logic        data_last;

	assign in_ready  = !out_valid || out_ready;
	assign accept    = in_valid && in_ready;
	assign len7      = frame_byte[6:0];
	assign hdr_flags = {frame_byte[7], flags_q[FLAG_FIN]};
	assign ext_len   = {plen_q[15:8], frame_byte};
	assign count_inc = count_q + 16'd1;
	assign data_last = ({1'b0, count_q} + 17'd1) >= {1'b0, plen_q};

	always_comb begin
		case (count_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		flags_d    = flags_q;
		plen_d     = plen_q;
		count_d    = count_q;
		key_d      = key_q;
		res_vld    = 1'b0;
		res_byte   = 8'd0;
		res_last   = 1'b1;
		res_status = ST_DATA;
		res_len    = plen_q;
		if (start_of_frame) begin
			flags_d = {1'b0, frame_byte[7]};
			plen_d  = 16'd0;
			count_d = 16'd0;
			key_d   = 32'd0;
			phase_d = PH_HDR1;
		end else begin
			case (phase_q)
				PH_HDR1: begin
					flags_d = hdr_flags;
					if (hdr_flags != 2'b11) begin
						phase_d    = PH_IDLE;
						res_vld    = 1'b1;
						res_status = ST_BADHDR;
						res_len    = {9'd0, len7};
					end else if (len7 == LEN_EXT64) begin
						phase_d    = PH_IDLE;
						res_vld    = 1'b1;
						res_status = ST_LEN64;
						res_len    = {9'd0, len7};
					end else if (len7 == LEN_EXT16) begin
						phase_d = PH_EXT_HI;
					end else begin
						plen_d = {9'd0, len7};
						if ({9'd0, len7} > max_len_q) begin
							phase_d    = PH_IDLE;
							res_vld    = 1'b1;
							res_status = ST_TOOLONG;
							res_len    = {9'd0, len7};
						end else begin
							phase_d = PH_MASK;
							count_d = 16'd0;
						end
					end
				end
				PH_EXT_HI: begin
					plen_d  = {frame_byte, 8'd0};
					phase_d = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					plen_d = ext_len;
					if (ext_len > max_len_q) begin
						phase_d    = PH_IDLE;
						res_vld    = 1'b1;
						res_status = ST_TOOLONG;
						res_len    = ext_len;
					end else begin
						phase_d = PH_MASK;
						count_d = 16'd0;
					end
				end
				PH_MASK: begin
					key_d   = {key_q[23:0], frame_byte};
					count_d = count_inc;
					if (count_inc >= MASK_BYTES) begin
						count_d = 16'd0;
						if (plen_q == 16'd0) begin
							phase_d    = PH_IDLE;
							res_vld    = 1'b1;
							res_status = ST_EMPTY;
							res_len    = 16'd0;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					count_d  = count_inc;
					res_vld  = 1'b1;
					res_byte = frame_byte ^ key_byte;
					res_last = data_last;
					if (data_last) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					// drop bytes outside a frame
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			flags_q <= 2'b00;
			plen_q  <= 16'd0;
			count_q <= 16'd0;
			key_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			plen_q  <= plen_d;
			count_q <= count_d;
			key_q   <= key_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= accept && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_vld) begin
			payload_byte <= res_byte;
			last         <= res_last;
			status       <= res_status;
			frame_length <= res_len;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/wsfu_checker.sv -----
// Port-level checks for the websocket frame unmask block, bound to the top level.
`default_nettype none
module wsfu_checker
	import wsfu_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        start_of_frame,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  payload_byte,
	input wire logic        last,
	input wire logic [2:0]  status,
	input wire logic [15:0] frame_length
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte))
		else $error("result beat dropped or changed while stalled");

	// input stalls only behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a pending result");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DATA |-> last && payload_byte == 8'd0)
		else $error("status beat not last or carries data");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> frame_length == 16'd0)
		else $error("empty frame with nonzero length");

	// a start byte never produces a beat
	a_sof_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && start_of_frame && !(out_valid && !out_ready) |=> !out_valid)
		else $error("result beat after start byte");

endmodule

bind websocket_frame_unmask wsfu_checker u_wsfu_checker (.*);
`default_nettype wire
